/* src/imu_rot_pkg.sv */
`timescale 1ns / 1ps
package imu_rot_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ALPHA_ONE = 32768;
    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_BIAS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_BIAS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LEVER = 3'd7;

    typedef struct packed {
        logic signed [31:0] angle_x_in;
        logic signed [31:0] angle_y_in;
        logic signed [31:0] angle_z_in;
        logic signed [31:0] rate_x_in;
        logic signed [31:0] rate_y_in;
        logic signed [31:0] rate_z_in;
        logic signed [31:0] acc_x_in;
        logic signed [31:0] acc_y_in;
        logic signed [31:0] acc_z_in;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] angle_x_out;
        logic signed [31:0] angle_y_out;
        logic signed [31:0] angle_z_out;
        logic signed [31:0] rate_x_out;
        logic signed [31:0] rate_y_out;
        logic signed [31:0] rate_z_out;
        logic signed [31:0] lin_acc_x;
        logic signed [31:0] lin_acc_y;
        logic signed [31:0] lin_acc_z;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;
endpackage

/* src/imu_rot_if.sv */
`timescale 1ns / 1ps
interface imu_rot_if #(
    parameter type payload_t = logic
);
    logic valid;
    logic ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* src/imu_rot_mac.sv */
`timescale 1ns / 1ps
// Shared multiply-accumulate: one signed 40x33 product per cycle while enabled.
module imu_rot_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                enable,
    input  logic                negate,
    input  logic signed [39:0]  op_a,
    input  logic signed [32:0]  op_b,
    output logic signed [95:0]  acc
);
    logic signed [95:0] acc_reg;
    logic signed [95:0] acc_next;
    logic signed [72:0] prod;

    always_comb
    begin
        prod = op_a * op_b;
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (enable)
        begin
            if (negate)
            begin
                acc_next = acc_reg - 96'(prod);
            end
            else
            begin
                acc_next = acc_reg + 96'(prod);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;
endmodule

/* src/imu_frame_rotate_filter_correct.sv */
`timescale 1ns / 1ps
// IMU sample conditioning: rotate angle, rate and acceleration vectors into
// the world frame, remove biases, low-pass filter all nine channels, scale
// angles and rates to radians and remove the centrifugal term w x (w x r).
//
// Channels: sample_in (sink) carries one request of nine Q16.16 values,
// result_out (source) one request of nine Q16.16 results, cfg (sink) writes
// one register per request at index 0..7; write only while idle.
// Work per sample: the one shared multiply-accumulate unit forms 9 channels x
// (3 rotation + 2 filter) products, 6 radian products and 12 cross-product
// terms; between them results are rounded and saturated, then the output
// register is loaded and the sequencer returns to idle to take the next
// sample. sample_in is not ready while a sample is in work, so a new sample
// is taken only once the last one is through; the result is held in an
// output register until taken, and a new sample is taken while that result
// waits, so a stalled receiver only holds the sequencer at the point where
// it has a new result to write.
// Reset: registers return to an identity matrix, zero biases, alpha zero,
// zero lever arm, and all filter memories clear to zero.
module imu_frame_rotate_filter_correct (
    input  logic clk,
    input  logic rst_n,
    imu_rot_if.sink   sample_in,
    imu_rot_if.source result_out,
    imu_rot_if.sink   cfg
);
    localparam int DW = imu_rot_pkg::DATA_WIDTH_DEF;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ROT   = 9'b000000010,
        ST_FILT  = 9'b000000100,
        ST_STORE = 9'b000001000,
        ST_RAD   = 9'b000010000,
        ST_RADW  = 9'b000100000,
        ST_CRS   = 9'b001000000,
        ST_CRSW  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [47:0] rot_reg [3];
    logic [62:0] bias_reg [3];   // angle, rate, accel
    logic [15:0] alpha_reg;
    logic [62:0] lever_reg;

    logic signed [DW-1:0] mem_reg [9];
    logic signed [31:0]   in_reg [9];
    logic signed [31:0]   res_reg [9];   // working results
    logic signed [31:0]   wr_reg [3];
    imu_rot_pkg::result_t out_reg;
    logic                 out_valid_reg;

    logic [3:0] ch_reg;     // channel 0..8
    logic [1:0] tm_reg;     // term counter
    logic [1:0] cr_reg;     // cross pass: 0 = w x r, 1 = w x wr

    // MAC drive
    logic                clr, en, neg;
    logic signed [39:0]  op_a;
    logic signed [32:0]  op_b;
    logic signed [95:0]  acc;

    imu_rot_mac u_mac (
        .clk(clk), .rst_n(rst_n), .clear(clr), .enable(en), .negate(neg),
        .op_a(op_a), .op_b(op_b), .acc(acc)
    );

    function automatic logic signed [95:0] sat_w(input logic signed [95:0] v,
                                                  input int w);
        logic signed [95:0] hi;
        logic signed [95:0] lo;
        begin
            hi = (96'sd1 <<< (w - 1)) - 96'sd1;
            lo = -hi - 96'sd1;
            sat_w = (v > hi) ? hi : ((v < lo) ? lo : v);
        end
    endfunction

    // split the channel into group (angle, rate, accel) and axis
    logic [1:0] grp;
    logic [1:0] axis;
    always_comb
    begin
        priority if (ch_reg < 4'd3)
        begin
            grp = 2'd0;
        end
        else if (ch_reg < 4'd6)
        begin
            grp = 2'd1;
        end
        else
        begin
            grp = 2'd2;
        end
        axis = 2'(ch_reg - 4'(grp) * 4'd3);
    end

    logic [15:0] alpha_c;
    assign alpha_c = (alpha_reg > 16'(imu_rot_pkg::ALPHA_ONE)) ?
                     16'(imu_rot_pkg::ALPHA_ONE) : alpha_reg;

    // rounded rotation, bias-corrected, filter and cross-product results
    logic signed [95:0] rot_v, bias_v, filt_v, rad_v, crs_v;
    logic signed [20:0] bsel;
    logic [1:0] bg;
    always_comb
    begin
        bg = 2'd0;
        unique case (grp)
            2'd0: bg = 2'd0;
            2'd1: bg = 2'd1;
            2'd2: bg = 2'd2;
            default: bg = 2'd0;
        endcase
        bsel   = $signed(bias_reg[bg][21*axis +: 21]);
        rot_v  = sat_w((acc + 96'sd8192) >>> 14, DW);
        bias_v = sat_w(rot_v - 96'(bsel), DW);
        filt_v = sat_w((acc + 96'sd16384) >>> 15, DW);
        crs_v  = sat_w((acc + 96'sd32768) >>> 16, 32);
    end

    // radians: magnitude clamp, Q0.32 multiply, ties away from zero
    logic        rneg;
    logic [37:0] rmag;
    logic [63:0] rmag_full;
    always_comb
    begin
        rneg = res_reg[ch_reg][31];
        rmag_full = rneg ? 64'(-65'($signed(res_reg[ch_reg]))) :
                           64'($signed(res_reg[ch_reg]));
        rmag = (rmag_full > 64'(38'h20_0000_0000)) ? 38'h20_0000_0000 : 38'(rmag_full);
        rad_v = (acc + 96'sd2147483648) >>> 32;
        rad_v = sat_w(rneg ? -rad_v : rad_v, 32);
    end

    // cross product operands; component i: a[i+1]*b[i+2] - a[i+2]*b[i+1]
    logic [1:0] ci1, ci2;
    logic signed [32:0] bvec [3];
    always_comb
    begin
        ci1 = (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        ci2 = (axis == 2'd0) ? 2'd2 : axis - 2'd1;
        for (int i = 0; i < 3; i++)
        begin
            bvec[i] = (cr_reg == 2'd0) ? 33'($signed(lever_reg[21*i +: 21])) :
                                         33'(wr_reg[i]);
        end
    end

    // take a new sample whenever idle, even while a result waits
    assign sample_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign result_out.valid = out_valid_reg;
    assign result_out.payload = out_reg;

    always_comb
    begin
        clr = 1'b0;
        en = 1'b0;
        neg = 1'b0;
        op_a = '0;
        op_b = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                clr = 1'b1;
                if (sample_in.valid && sample_in.ready)
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                en = 1'b1;
                op_a = 40'($signed(rot_reg[axis][16*tm_reg +: 16]));
                op_b = 33'(in_reg[4'(grp) * 4'd3 + 4'(tm_reg)]);
                if (tm_reg == 2'd2)
                begin
                    state_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                en = tm_reg == 2'd0 ? 1'b1 : 1'b1;
                clr = (tm_reg == 2'd0);
                if (tm_reg == 2'd0)
                begin
                    clr = 1'b1;
                    en = 1'b0;
                end
                else if (tm_reg == 2'd1)
                begin
                    op_a = 40'(mem_reg[ch_reg]);
                    op_b = 33'(alpha_c);
                end
                else
                begin
                    op_a = 40'(res_reg[ch_reg]);
                    op_b = 33'(17'(imu_rot_pkg::ALPHA_ONE) - 17'(alpha_c));
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                clr = 1'b1;
                state_next = (ch_reg == 4'd8) ? ST_RAD : ST_ROT;
            end
            ST_RAD:
            begin
                en = 1'b1;
                op_a = 40'(rmag);
                op_b = 33'(imu_rot_pkg::DEG2RAD_Q32);
                state_next = ST_RADW;
            end
            ST_RADW:
            begin
                clr = 1'b1;
                state_next = (ch_reg == 4'd5) ? ST_CRS : ST_RAD;
            end
            ST_CRS:
            begin
                en = 1'b1;
                neg = tm_reg[0];
                op_a = 40'(tm_reg[0] ? res_reg[4'd3 + 4'(ci2)] : res_reg[4'd3 + 4'(ci1)]);
                op_b = tm_reg[0] ? bvec[ci1] : bvec[ci2];
                if (tm_reg[0])
                begin
                    state_next = ST_CRSW;
                end
            end
            ST_CRSW:
            begin
                clr = 1'b1;
                if (axis == 2'd2 && cr_reg == 2'd1)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_CRS;
                end
            end
            ST_OUT:
            begin
                clr = 1'b1;
                if (!out_valid_reg || result_out.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg <= '0;
            tm_reg <= '0;
            cr_reg <= '0;
            out_valid_reg <= 1'b0;
            rot_reg[0] <= 48'h0000_0000_4000;
            rot_reg[1] <= 48'h0000_4000_0000;
            rot_reg[2] <= 48'h4000_0000_0000;
            for (int i = 0; i < 3; i++)
            begin
                bias_reg[i] <= '0;
            end
            alpha_reg <= '0;
            lever_reg <= '0;
            for (int i = 0; i < 9; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // load a new result when the output register is free or being taken
            priority if (state_reg == ST_OUT && (!out_valid_reg || result_out.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.valid && result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.payload.index)
                    imu_rot_pkg::REG_ROT_X:     rot_reg[0] <= cfg.payload.data[47:0];
                    imu_rot_pkg::REG_ROT_Y:     rot_reg[1] <= cfg.payload.data[47:0];
                    imu_rot_pkg::REG_ROT_Z:     rot_reg[2] <= cfg.payload.data[47:0];
                    imu_rot_pkg::REG_ACC_BIAS:  bias_reg[2] <= cfg.payload.data[62:0];
                    imu_rot_pkg::REG_RATE_BIAS: bias_reg[1] <= cfg.payload.data[62:0];
                    imu_rot_pkg::REG_ANG_BIAS:  bias_reg[0] <= cfg.payload.data[62:0];
                    imu_rot_pkg::REG_ALPHA:     alpha_reg <= cfg.payload.data[15:0];
                    imu_rot_pkg::REG_LEVER:     lever_reg <= cfg.payload.data[62:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    ch_reg <= '0;
                    tm_reg <= '0;
                    cr_reg <= '0;
                end
                ST_ROT:
                begin
                    tm_reg <= (tm_reg == 2'd2) ? 2'd0 : tm_reg + 2'd1;
                end
                ST_FILT:
                begin
                    // term 0 latches the bias-corrected rotation value
                    tm_reg <= (tm_reg == 2'd2) ? 2'd0 : tm_reg + 2'd1;
                end
                ST_STORE:
                begin
                    mem_reg[ch_reg] <= DW'(filt_v);
                    res_reg[ch_reg] <= 32'(sat_w(filt_v, 32));
                    ch_reg <= (ch_reg == 4'd8) ? 4'd0 : ch_reg + 4'd1;
                end
                ST_RAD: ;
                ST_RADW:
                begin
                    res_reg[ch_reg] <= 32'(rad_v);
                    ch_reg <= (ch_reg == 4'd5) ? 4'd0 : ch_reg + 4'd1;
                end
                ST_CRS:
                begin
                    tm_reg <= tm_reg[0] ? 2'd0 : 2'd1;
                end
                ST_CRSW:
                begin
                    if (cr_reg == 2'd0)
                    begin
                        wr_reg[axis] <= 32'(crs_v);
                    end
                    else
                    begin
                        res_reg[4'd6 + 4'(axis)] <= 32'(sat_w(
                            96'(res_reg[4'd6 + 4'(axis)]) - crs_v, 32));
                    end
                    if (axis == 2'd2)
                    begin
                        ch_reg <= '0;
                        cr_reg <= cr_reg + 2'd1;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 4'd1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || result_out.ready)
                    begin
                        out_reg <= {res_reg[0], res_reg[1], res_reg[2],
                                    res_reg[3], res_reg[4], res_reg[5],
                                    res_reg[6], res_reg[7], res_reg[8]};
                    end
                end
                default: ;
            endcase
            if (state_reg == ST_FILT && tm_reg == 2'd0)
            begin
                res_reg[ch_reg] <= 32'(bias_v);
            end
        end
    end

    // capture the sample
    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            in_reg[0] <= sample_in.payload.angle_x_in;
            in_reg[1] <= sample_in.payload.angle_y_in;
            in_reg[2] <= sample_in.payload.angle_z_in;
            in_reg[3] <= sample_in.payload.rate_x_in;
            in_reg[4] <= sample_in.payload.rate_y_in;
            in_reg[5] <= sample_in.payload.rate_z_in;
            in_reg[6] <= sample_in.payload.acc_x_in;
            in_reg[7] <= sample_in.payload.acc_y_in;
            in_reg[8] <= sample_in.payload.acc_z_in;
        end
    end
endmodule
